// ===== hdl/ssi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_pkg
// shared widths, constants and pipeline item types of the step interpolator
// ----------------------------------------------------------------------------
package ssi_pkg;

    localparam int POS_W      = 24;               // position field width
    localparam int STEP_W     = 20;               // step register width
    localparam int DEL_W      = POS_W + 1;        // difference / magnitude width
    localparam int SQ_W       = 2 * DEL_W;        // sum of squares width
    localparam int ROOT_W     = DEL_W;            // floor square root width
    localparam int REM_W      = ROOT_W + 3;       // square root remainder width
    localparam int PROD_W     = DEL_W + STEP_W;   // magnitude times step
    localparam int QUO_W      = DEL_W;            // quotient never exceeds magnitude
    localparam int NAXIS      = 3;
    localparam int DATA_IN_W  = 6 * POS_W;
    localparam int DATA_OUT_W = 3 * POS_W;

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(51);

    // context carried alongside every item
    typedef struct packed {
        logic [NAXIS-1:0][POS_W-1:0] cur;
        logic [NAXIS-1:0][POS_W-1:0] tgt;
        logic [NAXIS-1:0]            neg;
        logic [NAXIS-1:0][DEL_W-1:0] mag;
    } ctx_t;

    // item moving through the square root cells
    typedef struct packed {
        logic              valid;
        logic [SQ_W-1:0]   rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        ctx_t              ctx;
    } sq_t;

    // item moving through the divider cells, three lanes share one divisor
    typedef struct packed {
        logic                        valid;
        logic                        reached;
        logic [ROOT_W-1:0]           den;
        logic [NAXIS-1:0][ROOT_W-1:0] rem;
        logic [NAXIS-1:0][QUO_W-1:0] nlo;
        logic [NAXIS-1:0][QUO_W-1:0] quo;
        ctx_t                        ctx;
    } dv_t;

endpackage

// ===== hdl/setpoint_step_interpolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setpoint_step_interpolator
// moves a 3d commanded position at most one step toward a target
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one item holds current and target position (x, y, z each,
//   24-bit two's complement, 1/1024 m). m_ channel returns the next position
//   in tdata and the reached flag in tuser.
//   cfg channel writes the 20-bit step size; it is always ready and should be
//   written only while no item is in flight. Reset value is 51.
//   Throughput: one item per cycle while the output is not stalled. Each item
//   passes through 55 register stages from acceptance to the output register:
//   the 25 square root cells, the 25 divider cells and five arithmetic stages.
//   Reset clears every valid bit and loads the default step size.
//   When the receiver stalls with a result held, the whole pipeline freezes
//   and s_tready drops in the same cycle; it rises again as soon as the held
//   result is taken.
// ----------------------------------------------------------------------------
module setpoint_step_interpolator (
    input  logic                              aclk,
    input  logic                              aresetn,
    // cur_x, cur_y, cur_z, tgt_x, tgt_y, tgt_z
    input  logic [ssi_pkg::DATA_IN_W-1:0]     s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // next_x, next_y, next_z
    output logic [ssi_pkg::DATA_OUT_W-1:0]    m_tdata,
    // reached
    output logic                              m_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [ssi_pkg::STEP_W-1:0]        cfg_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready
);

    localparam int NCELL = ssi_pkg::ROOT_W;

    logic en;
    logic [ssi_pkg::STEP_W-1:0] step_reg;

    // stage registers ahead of the square root
    logic                                   v0_reg, v1_reg, v2_reg;
    ssi_pkg::ctx_t                          ctx0_reg, ctx1_reg, ctx2_reg;
    logic [ssi_pkg::NAXIS-1:0][ssi_pkg::SQ_W-1:0] sq1_reg;
    logic [ssi_pkg::SQ_W-1:0]               sum2_reg;
    ssi_pkg::ctx_t                          ctx0_next;

    ssi_pkg::sq_t sq_head;
    ssi_pkg::sq_t sq_chain [NCELL+1];
    ssi_pkg::dv_t dv_chain [NCELL+1];
    ssi_pkg::dv_t dv_in_reg;
    ssi_pkg::dv_t dv_in_next;

    logic [ssi_pkg::PROD_W-1:0]          prod;
    logic [ssi_pkg::ROOT_W-1:0]          droot;
    logic [ssi_pkg::DATA_OUT_W-1:0]      m_tdata_reg, m_tdata_next;
    logic                                m_tuser_reg, m_tvalid_reg;

    assign en        = !m_tvalid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // step size register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= ssi_pkg::STEP_RESET;
        end else if (cfg_valid) begin
            step_reg <= cfg_data;
        end
    end

    // differences, signs and magnitudes
    always_comb begin
        logic [ssi_pkg::DEL_W-1:0] del;
        del = '0;
        ctx0_next = '0;
        for (int i = 0; i < ssi_pkg::NAXIS; i++) begin
            ctx0_next.cur[i] = s_tdata[i*ssi_pkg::POS_W +: ssi_pkg::POS_W];
            ctx0_next.tgt[i] = s_tdata[(i+3)*ssi_pkg::POS_W +: ssi_pkg::POS_W];
            del = {ctx0_next.tgt[i][ssi_pkg::POS_W-1], ctx0_next.tgt[i]}
                - {ctx0_next.cur[i][ssi_pkg::POS_W-1], ctx0_next.cur[i]};
            ctx0_next.neg[i] = del[ssi_pkg::DEL_W-1];
            ctx0_next.mag[i] = del[ssi_pkg::DEL_W-1] ? -del : del;
        end
    end

    // input, square and sum stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v0_reg   <= s_tvalid;
            ctx0_reg <= ctx0_next;
            v1_reg   <= v0_reg;
            ctx1_reg <= ctx0_reg;
            for (int i = 0; i < ssi_pkg::NAXIS; i++) begin
                sq1_reg[i] <= ssi_pkg::SQ_W'(ctx0_reg.mag[i] * ctx0_reg.mag[i]);
            end
            v2_reg   <= v1_reg;
            ctx2_reg <= ctx1_reg;
            sum2_reg <= sq1_reg[0] + sq1_reg[1] + sq1_reg[2];
        end
    end

    // square root chain
    always_comb begin
        sq_head       = '0;
        sq_head.valid = v2_reg;
        sq_head.rad   = sum2_reg;
        sq_head.ctx   = ctx2_reg;
    end

    assign sq_chain[0] = sq_head;

    for (genvar g = 0; g < NCELL; g++) begin : g_sqrt
        ssi_sqrt_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .din     (sq_chain[g]),
            .dout    (sq_chain[g+1])
        );
    end

    // decide and scale magnitudes by the step
    always_comb begin
        droot      = sq_chain[NCELL].root;
        dv_in_next = '0;
        prod       = '0;
        dv_in_next.valid   = sq_chain[NCELL].valid;
        dv_in_next.reached = (droot == '0)
                           || (droot < ssi_pkg::ROOT_W'(step_reg));
        dv_in_next.den     = droot;
        dv_in_next.ctx     = sq_chain[NCELL].ctx;
        for (int i = 0; i < ssi_pkg::NAXIS; i++) begin
            prod = ssi_pkg::PROD_W'(sq_chain[NCELL].ctx.mag[i] * step_reg);
            dv_in_next.rem[i] = ssi_pkg::ROOT_W'(prod[ssi_pkg::PROD_W-1:ssi_pkg::QUO_W]);
            dv_in_next.nlo[i] = prod[ssi_pkg::QUO_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_in_reg.valid <= 1'b0;
        end else if (en) begin
            dv_in_reg <= dv_in_next;
        end
    end

    assign dv_chain[0] = dv_in_reg;

    // divider chain
    for (genvar g = 0; g < NCELL; g++) begin : g_div
        ssi_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .din     (dv_chain[g]),
            .dout    (dv_chain[g+1])
        );
    end

    // apply the move or take the target
    always_comb begin
        m_tdata_next = '0;
        for (int i = 0; i < ssi_pkg::NAXIS; i++) begin
            if (dv_chain[NCELL].reached) begin
                m_tdata_next[i*ssi_pkg::POS_W +: ssi_pkg::POS_W] =
                    dv_chain[NCELL].ctx.tgt[i];
            end else if (dv_chain[NCELL].ctx.neg[i]) begin
                m_tdata_next[i*ssi_pkg::POS_W +: ssi_pkg::POS_W] =
                    dv_chain[NCELL].ctx.cur[i]
                    - dv_chain[NCELL].quo[i][ssi_pkg::POS_W-1:0];
            end else begin
                m_tdata_next[i*ssi_pkg::POS_W +: ssi_pkg::POS_W] =
                    dv_chain[NCELL].ctx.cur[i]
                    + dv_chain[NCELL].quo[i][ssi_pkg::POS_W-1:0];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= dv_chain[NCELL].valid;
            m_tdata_reg  <= m_tdata_next;
            m_tuser_reg  <= dv_chain[NCELL].reached;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // square root remainder stays within its bound
    a_sqrt_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_chain[NCELL].valid |->
            ({1'b0, sq_chain[NCELL].rem} <= {sq_chain[NCELL].root, 1'b0}))
        else $error("sqrt remainder out of range");

    // each division remainder stays below the divisor on the moving path
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (dv_chain[NCELL].valid && !dv_chain[NCELL].reached) |->
            (dv_chain[NCELL].rem[0] < dv_chain[NCELL].den
             && dv_chain[NCELL].rem[1] < dv_chain[NCELL].den
             && dv_chain[NCELL].rem[2] < dv_chain[NCELL].den))
        else $error("divider remainder out of range");

    // a stalled result freezes the whole pipeline
    a_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(dv_chain[NCELL]))
        else $error("pipeline moved while output stalled");

endmodule

// ===== hdl/ssi_sqrt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_sqrt_cell
// one digit step of a restoring square root, registered
// ----------------------------------------------------------------------------
module ssi_sqrt_cell (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  ssi_pkg::sq_t  din,
    output ssi_pkg::sq_t  dout
);

    ssi_pkg::sq_t dout_reg;
    ssi_pkg::sq_t dout_next;

    logic [ssi_pkg::REM_W-1:0] rem_sh;
    logic [ssi_pkg::REM_W-1:0] trial;

    // bring down two radicand bits and try the next root bit
    always_comb begin
        rem_sh    = {din.rem[ssi_pkg::REM_W-3:0], din.rad[ssi_pkg::SQ_W-1 -: 2]};
        trial     = ssi_pkg::REM_W'({din.root, 2'b01});
        dout_next = din;
        dout_next.rad = {din.rad[ssi_pkg::SQ_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
            dout_next.rem  = rem_sh - trial;
            dout_next.root = {din.root[ssi_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            dout_next.rem  = rem_sh;
            dout_next.root = {din.root[ssi_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dout_reg.valid <= 1'b0;
        end else if (en) begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

// ===== hdl/ssi_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_div_cell
// one quotient bit of three restoring divisions sharing a divisor, registered
// ----------------------------------------------------------------------------
module ssi_div_cell (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  ssi_pkg::dv_t  din,
    output ssi_pkg::dv_t  dout
);

    ssi_pkg::dv_t dout_reg;
    ssi_pkg::dv_t dout_next;

    logic [ssi_pkg::ROOT_W:0] rem_sh;

    // shift in one dividend bit per lane and subtract where it fits
    always_comb begin
        dout_next = din;
        rem_sh    = '0;
        for (int i = 0; i < ssi_pkg::NAXIS; i++) begin
            rem_sh = {din.rem[i], din.nlo[i][ssi_pkg::QUO_W-1]};
            dout_next.nlo[i] = {din.nlo[i][ssi_pkg::QUO_W-2:0], 1'b0};
            if (rem_sh >= {1'b0, din.den}) begin
                dout_next.rem[i] = ssi_pkg::ROOT_W'(rem_sh - {1'b0, din.den});
                dout_next.quo[i] = {din.quo[i][ssi_pkg::QUO_W-2:0], 1'b1};
            end else begin
                dout_next.rem[i] = rem_sh[ssi_pkg::ROOT_W-1:0];
                dout_next.quo[i] = {din.quo[i][ssi_pkg::QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dout_reg.valid <= 1'b0;
        end else if (en) begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

// ===== dv/setpoint_step_interpolator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setpoint_step_interpolator_tb
// Self-checking bench for the 3d step interpolator. Each accepted position
// pair is run through a behavioral copy of the step rule (exact distance,
// floor square root, truncated scaling). The expected next positions are
// queued and then compared with the output stream. The run goes through
// several step sizes and through phases of random sender gaps and receiver
// stalls.
// ----------------------------------------------------------------------------
module setpoint_step_interpolator_tb;
    import ssi_pkg::*;

    localparam int LATENCY = 55;
    localparam longint CYCLE_LIMIT = 400000;
    localparam int HOLD_LEN = 300;

    typedef struct {
        logic [POS_W-1:0] nx, ny, nz;
        logic             reached;
    } step_result_t;

    // holds the expected next positions and checks each result against them
    class step_scoreboard;
        step_result_t pending[$];
        logic [STEP_W-1:0] step;
        int mismatches;

        function new();
            step = STEP_RESET;
            mismatches = 0;
        endfunction

        // floor square root of a sum of squares
        function automatic longint unsigned root_floor(logic [127:0] s);
            longint unsigned r;
            logic [127:0] c;
            r = 0;
            for (int b = 33; b >= 0; b--) begin
                c = 128'(r | (64'd1 << b));
                if (c * c <= s) r = r | (64'd1 << b);
            end
            return r;
        endfunction

        function void note_input(logic [DATA_IN_W-1:0] d);
            longint cur[3], tgt[3], del[3], nv;
            longint unsigned m, q, d_root;
            logic [127:0] sum;
            step_result_t r;
            sum = 0;
            for (int i = 0; i < 3; i++) begin
                cur[i] = longint'($signed(d[i*POS_W +: POS_W]));
                tgt[i] = longint'($signed(d[(i+3)*POS_W +: POS_W]));
                del[i] = tgt[i] - cur[i];
                m = del[i] < 0 ? -del[i] : del[i];
                sum += 128'(m) * 128'(m);
            end
            d_root = root_floor(sum);
            if (d_root == 0 || d_root < step) begin
                r.nx = tgt[0][POS_W-1:0];
                r.ny = tgt[1][POS_W-1:0];
                r.nz = tgt[2][POS_W-1:0];
                r.reached = 1'b1;
            end else begin
                for (int i = 0; i < 3; i++) begin
                    m = del[i] < 0 ? -del[i] : del[i];
                    q = (m * step) / d_root;
                    nv = del[i] < 0 ? cur[i] - longint'(q) : cur[i] + longint'(q);
                    if (i == 0) r.nx = nv[POS_W-1:0];
                    else if (i == 1) r.ny = nv[POS_W-1:0];
                    else r.nz = nv[POS_W-1:0];
                end
                r.reached = 1'b0;
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic [DATA_OUT_W-1:0] d, logic rch);
            step_result_t e;
            logic bad;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h %b", d, rch);
                return;
            end
            e = pending.pop_front();
            bad = (d[0 +: POS_W] !== e.nx) || (d[POS_W +: POS_W] !== e.ny) ||
                  (d[2*POS_W +: POS_W] !== e.nz) || (rch !== e.reached);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch exp x=%h y=%h z=%h r=%b got x=%h y=%h z=%h r=%b",
                             e.nx, e.ny, e.nz, e.reached, d[0 +: POS_W],
                             d[POS_W +: POS_W], d[2*POS_W +: POS_W], rch);
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic [DATA_IN_W-1:0] s_tdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [DATA_OUT_W-1:0] m_tdata;
    logic m_tuser, m_tvalid;
    logic m_tready = 1'b0;
    logic [STEP_W-1:0] cfg_data = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_cycles = 0;
    longint cycles = 0;
    step_scoreboard board;

    setpoint_step_interpolator dut (.*);

    always #6 aclk = ~aclk;

    // run-time limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("setpoint_step_interpolator verification failed");
            $finish;
        end
    end

    // receiver side: random stalls plus a counted long hold-off
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
        if (hold_reqs != hold_seen) begin
            hold_seen <= hold_reqs;
            hold_cycles <= HOLD_LEN - 1;
            m_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // offer one item, with a random gap first, and wait for acceptance
    task automatic send_item(logic [DATA_IN_W-1:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata <= d;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        board.note_input(d);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    task automatic write_step(logic [STEP_W-1:0] v);
        drain();
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        board.step = v;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [POS_W-1:0] rnd_pos();
        return POS_W'($urandom);
    endfunction

    // pack cur and tgt, x first in the lowest bits
    function automatic logic [DATA_IN_W-1:0] pack_pair(logic [POS_W-1:0] cx, cy, cz,
                                                       tx, ty, tz);
        return {tz, ty, tx, cz, cy, cx};
    endfunction

    // random pair: mostly nearby targets so both outcomes occur
    function automatic logic [DATA_IN_W-1:0] rnd_pair();
        logic [POS_W-1:0] c[3], t[3];
        int span;
        case ($urandom_range(3))
            0: span = 64;
            1: span = 4096;
            2: span = 1 << 20;
            default: span = 0;
        endcase
        for (int i = 0; i < 3; i++) begin
            c[i] = rnd_pos();
            if (span == 0) t[i] = rnd_pos();
            else t[i] = c[i] + POS_W'($urandom_range(2*span) - span);
        end
        return pack_pair(c[0], c[1], c[2], t[0], t[1], t[2]);
    endfunction

    task automatic random_phase(int n, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (n) send_item(rnd_pair());
    endtask

    localparam logic [POS_W-1:0] PMAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic [POS_W-1:0] PMIN = {1'b1, {(POS_W-1){1'b0}}};

    initial begin
        board = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: zero distance, extremes, under one step, exactly one step
        send_item(pack_pair('0, '0, '0, '0, '0, '0));
        send_item(pack_pair(PMAX, PMIN, POS_W'(5), PMAX, PMIN, POS_W'(5)));
        send_item(pack_pair(PMIN, PMIN, PMIN, PMAX, PMAX, PMAX));
        send_item(pack_pair(PMAX, PMAX, PMAX, PMIN, PMIN, PMIN));
        send_item(pack_pair(PMIN, '0, PMAX, PMAX, '0, PMIN));
        send_item(pack_pair('0, '0, '0, POS_W'(50), '0, '0));
        send_item(pack_pair('0, '0, '0, POS_W'(51), '0, '0));
        send_item(pack_pair(POS_W'(10), POS_W'(10), POS_W'(10),
                            POS_W'(10), POS_W'(10), POS_W'(10 - 52)));
        send_item(pack_pair('0, '0, '0, POS_W'(30), POS_W'(30), POS_W'(30)));
        send_item(pack_pair('0, '0, '0, POS_W'(-30), POS_W'(40), '0));
        send_item(pack_pair('1, '1, '1, '0, '0, '0));

        // extreme step sizes, zero included
        write_step('0);
        send_item(pack_pair('0, '0, '0, '0, '0, '0));
        send_item(pack_pair('0, '0, '0, POS_W'(1), POS_W'(-1), POS_W'(1)));
        send_item(pack_pair(PMIN, PMIN, PMIN, PMAX, PMAX, PMAX));
        random_phase(40, 0, 0);
        write_step('1);
        send_item(pack_pair(PMIN, PMIN, PMIN, PMAX, PMAX, PMAX));
        send_item(pack_pair(PMIN, '0, '0, PMAX, '0, '0));
        random_phase(40, 0, 0);
        write_step(STEP_W'(1));
        send_item(pack_pair('0, '0, '0, POS_W'(1), '0, '0));
        send_item(pack_pair('0, '0, '0, POS_W'(1), POS_W'(1), '0));
        random_phase(100, 52, 0);
        write_step(STEP_W'(1000));
        random_phase(250, 0, 52);
        write_step(STEP_W'(51));
        random_phase(250, 0, 0);

        // long receiver hold-off while the sender keeps offering
        hold_reqs <= hold_reqs + 1;
        random_phase(150, 0, 0);

        // sender pauses until everything is back
        drain();
        write_step(20'($urandom));
        random_phase(250, 8, 8);

        drain();
        if (board.mismatches == 0)
            $display("setpoint_step_interpolator verification clean");
        else
            $display("setpoint_step_interpolator verification failed");
        $finish;
    end
endmodule
